FILE: hw/rtl/tccs_pkg.sv
// Shared types and constants for the text console cursor/scroll engine.
// No dependencies; used by the divider, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package tccs_pkg;

    // screen store geometry, tied to the 12-bit cursor
    localparam int CELL_COUNT  = 4096;
    localparam int CELL_AW     = 12;
    localparam int POS_W       = CELL_AW + 1;
    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 32;
    localparam int COL_W       = 8;
    localparam int ROW_W       = 6;
    localparam int DIV_STEPS   = CELL_AW;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // cell layout: background, foreground, character
    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;

    // request opcodes
    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_PUT_AT = 3'd1;
    localparam logic [2:0] OP_MOVE   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // configuration register indexes
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_GEO,
        S_MOVE_MUL,
        S_MOVE_SET,
        S_RD_MUL,
        S_RD_ADDR,
        S_RD_DATA,
        S_PUT_CHECK,
        S_PRE_DIV,
        S_PUT_MAIN,
        S_NL_DIV,
        S_ADVANCE,
        S_PUT_DONE,
        S_SCR_MUL,
        S_SCR_RUN,
        S_SCR_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

FILE: hw/rtl/tccs_cmd_if.sv
// Request channel of the text console engine: handshake plus command fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tccs_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] character;
    logic [3:0] foreground;
    logic [3:0] background;
    logic [7:0] row;
    logic [7:0] col;

    modport source (output valid, opcode, character, foreground, background, row, col,
                    input ready);
    modport sink   (input valid, opcode, character, foreground, background, row, col,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tccs_res_if.sv
// Result channel of the text console engine: handshake plus result fields.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tccs_res_if;
    logic        valid;
    logic        ready;
    logic [11:0] cursor_position;
    logic [7:0]  cell_character;
    logic [3:0]  cell_foreground;
    logic [3:0]  cell_background;
    logic [7:0]  lines_scrolled;

    modport source (output valid, cursor_position, cell_character, cell_foreground,
                    cell_background, lines_scrolled, input ready);
    modport sink   (input valid, cursor_position, cell_character, cell_foreground,
                    cell_background, lines_scrolled, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/text_console_cursor_scroll.sv
// Text console engine: screen cell store, cursor, scrolling and clearing.
// Depends on tccs_pkg, tccs_cmd_if, tccs_res_if and tccs_div.
//
// Usage: requests arrive on i_cmd (valid/ready), one result per request leaves on
// o_res (valid/ready). Geometry (columns, rows) is set through the write port
// i_cfg_we/i_cfg_idx/i_cfg_data while no request is in flight.
// One request is worked on at a time by a sequencer around a single 6x8 multiplier,
// a 12-step divider and one write / one read port of the cell memory.
// Unused opcodes, ignored moves and out-of-range reads go straight to the result.
// A scroll pass copies rows*columns cells, one cell per cycle; clear is one such
// pass, and a newline or an off-screen cursor adds a divider run.
// A new request is accepted as soon as the sequencer is idle, even while the previous
// result still waits in the output register; a stalled receiver holds the result and
// blocks only the completion of the following request.
// Reset: cursor 0, columns 80, rows 25, then a clearing pass writes a
// blank (space, color 0x0F) to every cell, with i_cmd.ready low until it ends.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    tccs_cmd_if.sink        i_cmd,
    tccs_res_if.source      o_res
);

    localparam int AW = tccs_pkg::CELL_AW;
    localparam int PW = tccs_pkg::POS_W;
    localparam int CW = tccs_pkg::COL_W;
    localparam int RW = tccs_pkg::ROW_W;

    tccs_pkg::t_state r_state, n_state, r_ret, n_ret;

    // configuration
    logic [7:0]    r_columns;
    logic [5:0]    r_rows;
    logic [CW-1:0] geo_c;
    logic [RW-1:0] geo_r;

    // latched request
    logic [2:0] r_op;
    logic [7:0] r_ch, r_row, r_col;
    logic [3:0] r_fg, r_bg;

    // working registers
    logic [AW-1:0] r_cursor, n_cursor;
    logic [PW-1:0] r_maxp, n_maxp;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_prod;
    logic [7:0]    r_sc, n_sc;
    logic [15:0]   r_cell, n_cell;
    logic [RW-1:0] r_k, n_k;
    logic [RW-1:0] r_rowe, n_rowe;
    logic [AW-1:0] r_i, n_i;

    // scroll copy stage
    logic          r_wr_valid;
    logic          r_wr_copy;
    logic [AW-1:0] r_wr_idx;

    // memory
    logic [15:0]   r_mem [tccs_pkg::CELL_COUNT];
    logic [15:0]   r_rdata;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    // output register
    logic        r_out_valid;
    logic [11:0] r_out_cursor;
    logic [15:0] r_out_cell;
    logic [7:0]  r_out_sc;
    logic        out_load;

    // shared units
    logic [RW-1:0]  mul_a;
    logic [RW+CW-1:0] mul_full;
    logic           div_start;
    logic [AW-1:0]  div_dividend;
    logic [AW-1:0]  div_quo;
    logic [CW-1:0]  div_rem;
    tccs_pkg::t_div_status div_st;

    // derived values
    logic          accept;
    logic [PW-1:0] sum_pc;
    logic [PW-1:0] src;
    logic          src_copy;
    logic          scr_last;
    logic [PW-1:0] pre_n;
    logic [7:0]    mv_n;
    logic          col_bad;
    logic          row_over;
    logic          rd_ok;
    logic          is_nl;

    // clamped geometry
    always_comb begin
        if (r_columns == 8'd0) begin
            geo_c = CW'(1);
        end else if (r_columns > 8'(tccs_pkg::MAX_COLUMNS)) begin
            geo_c = CW'(tccs_pkg::MAX_COLUMNS);
        end else begin
            geo_c = r_columns;
        end
        if (r_rows == 6'd0) begin
            geo_r = RW'(1);
        end else if (r_rows > 6'(tccs_pkg::MAX_ROWS)) begin
            geo_r = RW'(tccs_pkg::MAX_ROWS);
        end else begin
            geo_r = r_rows;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 8'd80;
            r_rows    <= 6'd25;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tccs_pkg::REG_COLUMNS: r_columns <= i_cfg_data;
                tccs_pkg::REG_ROWS:    r_rows    <= i_cfg_data[5:0];
                default:               r_columns <= r_columns;
            endcase
        end
    end

    // shared multiplier: every product is some row count times the column count
    always_comb begin
        case (r_state)
            tccs_pkg::S_SCR_MUL, tccs_pkg::S_SCR_RUN: mul_a = r_k;
            tccs_pkg::S_MOVE_MUL:                     mul_a = r_rowe;
            tccs_pkg::S_RD_MUL:                       mul_a = r_row[RW-1:0];
            default:                                  mul_a = geo_r;
        endcase
        mul_full = {{CW{1'b0}}, mul_a} * {{RW{1'b0}}, geo_c};
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[PW-1:0];
    end

    // divider for newline row and off-screen cursor
    tccs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (geo_c),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_status    (div_st)
    );

    // helpers
    always_comb begin
        accept   = i_cmd.valid && i_cmd.ready;
        sum_pc   = r_prod + {{(PW-8){1'b0}}, r_col};
        src      = {1'b0, r_i} + r_prod;
        src_copy = (src < r_maxp);
        scr_last = ({1'b0, r_i} == (r_maxp - PW'(1)));
        pre_n    = {1'b0, div_quo} + PW'(1);
        mv_n     = r_row - {2'b00, geo_r} + 8'd1;
        col_bad  = (r_col >= geo_c);
        row_over = (r_row >= {2'b00, geo_r});
        rd_ok    = !row_over && !col_bad;
        is_nl    = (r_ch == tccs_pkg::NEWLINE_CODE);
        out_load = (r_state == tccs_pkg::S_FINISH) && (!r_out_valid || o_res.ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tccs_pkg::S_INIT: begin
                if (r_i == AW'(tccs_pkg::CELL_COUNT - 1)) n_state = tccs_pkg::S_IDLE;
            end
            tccs_pkg::S_IDLE: begin
                if (accept) n_state = tccs_pkg::S_GEO;
            end
            tccs_pkg::S_GEO: begin
                case (r_op)
                    tccs_pkg::OP_PUT: n_state = tccs_pkg::S_PUT_CHECK;
                    tccs_pkg::OP_PUT_AT, tccs_pkg::OP_MOVE: begin
                        if (col_bad) begin
                            n_state = (r_op == tccs_pkg::OP_PUT_AT) ?
                                      tccs_pkg::S_PUT_CHECK : tccs_pkg::S_FINISH;
                        end else if (row_over) begin
                            n_state = tccs_pkg::S_SCR_MUL;
                        end else begin
                            n_state = tccs_pkg::S_MOVE_MUL;
                        end
                    end
                    tccs_pkg::OP_CLEAR: n_state = tccs_pkg::S_SCR_MUL;
                    tccs_pkg::OP_READ:
                        n_state = rd_ok ? tccs_pkg::S_RD_MUL : tccs_pkg::S_FINISH;
                    default: n_state = tccs_pkg::S_FINISH;
                endcase
            end
            tccs_pkg::S_MOVE_MUL: n_state = tccs_pkg::S_MOVE_SET;
            tccs_pkg::S_MOVE_SET: begin
                n_state = (r_op == tccs_pkg::OP_PUT_AT) ?
                          tccs_pkg::S_PUT_CHECK : tccs_pkg::S_FINISH;
            end
            tccs_pkg::S_RD_MUL:  n_state = tccs_pkg::S_RD_ADDR;
            tccs_pkg::S_RD_ADDR: n_state = tccs_pkg::S_RD_DATA;
            tccs_pkg::S_RD_DATA: n_state = tccs_pkg::S_FINISH;
            tccs_pkg::S_PUT_CHECK: begin
                n_state = ({1'b0, r_cursor} >= r_maxp) ?
                          tccs_pkg::S_PRE_DIV : tccs_pkg::S_PUT_MAIN;
            end
            tccs_pkg::S_PRE_DIV: begin
                if (div_st.done) n_state = tccs_pkg::S_SCR_MUL;
            end
            tccs_pkg::S_PUT_MAIN: begin
                n_state = is_nl ? tccs_pkg::S_NL_DIV : tccs_pkg::S_ADVANCE;
            end
            tccs_pkg::S_NL_DIV: begin
                if (div_st.done) n_state = tccs_pkg::S_ADVANCE;
            end
            tccs_pkg::S_ADVANCE: begin
                n_state = (r_pos >= r_maxp) ? tccs_pkg::S_SCR_MUL : tccs_pkg::S_PUT_DONE;
            end
            tccs_pkg::S_PUT_DONE: n_state = tccs_pkg::S_FINISH;
            tccs_pkg::S_SCR_MUL:  n_state = tccs_pkg::S_SCR_RUN;
            tccs_pkg::S_SCR_RUN: begin
                if (scr_last) n_state = tccs_pkg::S_SCR_DRAIN;
            end
            tccs_pkg::S_SCR_DRAIN: n_state = r_ret;
            tccs_pkg::S_FINISH: begin
                if (out_load) n_state = tccs_pkg::S_IDLE;
            end
            default: n_state = tccs_pkg::S_IDLE;
        endcase
    end

    // saturating scroll count, fed by the per-state increment
    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [PW-1:0] b);
        logic [PW:0] s;
        s = {{(PW-7){1'b0}}, a} + {1'b0, b};
        return (s > (PW+1)'(255)) ? 8'd255 : s[7:0];
    endfunction

    // datapath and control outputs
    always_comb begin
        n_cursor     = r_cursor;
        n_maxp       = r_maxp;
        n_pos        = r_pos;
        n_sc         = r_sc;
        n_cell       = r_cell;
        n_k          = r_k;
        n_rowe       = r_rowe;
        n_i          = r_i;
        n_ret        = r_ret;
        div_start    = 1'b0;
        div_dividend = r_pos[AW-1:0];
        rd_addr      = sum_pc[AW-1:0];
        mem_we       = 1'b0;
        mem_waddr    = r_wr_idx;
        mem_wdata    = tccs_pkg::BLANK_CELL;

        // scroll copy stage writes in the cycle after its read
        if (r_wr_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_wr_idx;
            mem_wdata = r_wr_copy ? r_rdata : tccs_pkg::BLANK_CELL;
        end

        case (r_state)
            tccs_pkg::S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = tccs_pkg::BLANK_CELL;
                n_i       = r_i + 1'b1;
            end
            tccs_pkg::S_IDLE: begin
                n_sc   = '0;
                n_cell = '0;
            end
            tccs_pkg::S_GEO: begin
                n_maxp = r_prod;
                case (r_op)
                    tccs_pkg::OP_PUT_AT, tccs_pkg::OP_MOVE: begin
                        n_rowe = row_over ? (geo_r - RW'(1)) : r_row[RW-1:0];
                        if (!col_bad && row_over) begin
                            n_sc  = sat_add(r_sc, {{(PW-8){1'b0}}, mv_n});
                            n_k   = (mv_n >= {2'b00, geo_r}) ? geo_r : mv_n[RW-1:0];
                            n_ret = tccs_pkg::S_MOVE_MUL;
                        end
                    end
                    tccs_pkg::OP_CLEAR: begin
                        n_k      = geo_r;
                        n_ret    = tccs_pkg::S_FINISH;
                        n_cursor = '0;
                    end
                    default: n_k = r_k;
                endcase
            end
            tccs_pkg::S_MOVE_SET: n_cursor = sum_pc[AW-1:0];
            tccs_pkg::S_RD_DATA:  n_cell   = r_rdata;
            tccs_pkg::S_PUT_CHECK: begin
                n_pos        = {1'b0, r_cursor};
                div_dividend = r_cursor - r_maxp[AW-1:0];
                div_start    = ({1'b0, r_cursor} >= r_maxp);
            end
            tccs_pkg::S_PRE_DIV: begin
                if (div_st.done) begin
                    n_sc  = sat_add(r_sc, pre_n);
                    n_k   = (pre_n >= {{(PW-RW){1'b0}}, geo_r}) ? geo_r : pre_n[RW-1:0];
                    n_pos = r_maxp + {{(PW-CW){1'b0}}, div_rem}
                            - {{(PW-CW){1'b0}}, geo_c};
                    n_ret = tccs_pkg::S_PUT_MAIN;
                end
            end
            tccs_pkg::S_PUT_MAIN: begin
                if (is_nl) begin
                    div_start    = 1'b1;
                    div_dividend = r_pos[AW-1:0];
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos[AW-1:0];
                    mem_wdata = {r_bg, r_fg, r_ch};
                    n_pos     = r_pos + PW'(1);
                end
            end
            tccs_pkg::S_NL_DIV: begin
                if (div_st.done) begin
                    n_pos = r_pos - {{(PW-CW){1'b0}}, div_rem}
                            + {{(PW-CW){1'b0}}, geo_c};
                end
            end
            tccs_pkg::S_ADVANCE: begin
                if (r_pos >= r_maxp) begin
                    n_sc  = sat_add(r_sc, PW'(1));
                    n_k   = RW'(1);
                    n_pos = r_pos - {{(PW-CW){1'b0}}, geo_c};
                    n_ret = tccs_pkg::S_PUT_DONE;
                end
            end
            tccs_pkg::S_PUT_DONE: n_cursor = r_pos[AW-1:0];
            tccs_pkg::S_SCR_MUL:  n_i = '0;
            tccs_pkg::S_SCR_RUN: begin
                rd_addr = src[AW-1:0];
                n_i     = r_i + 1'b1;
            end
            default: n_i = r_i;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tccs_pkg::S_INIT;
            r_ret      <= tccs_pkg::S_FINISH;
            r_i        <= '0;
            r_cursor   <= '0;
            r_wr_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_i        <= n_i;
            r_cursor   <= n_cursor;
            r_wr_valid <= (r_state == tccs_pkg::S_SCR_RUN);
        end
    end

    // working payload registers
    always_ff @(posedge i_clk) begin
        r_maxp    <= n_maxp;
        r_pos     <= n_pos;
        r_sc      <= n_sc;
        r_cell    <= n_cell;
        r_k       <= n_k;
        r_rowe    <= n_rowe;
        r_wr_copy <= src_copy;
        r_wr_idx  <= r_i;
        if (accept) begin
            r_op  <= i_cmd.opcode;
            r_ch  <= i_cmd.character;
            r_fg  <= i_cmd.foreground;
            r_bg  <= i_cmd.background;
            r_row <= i_cmd.row;
            r_col <= i_cmd.col;
        end
    end

    // cell memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[rd_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cursor <= r_cursor;
            r_out_cell   <= r_cell;
            r_out_sc     <= r_sc;
        end
    end

    assign i_cmd.ready           = (r_state == tccs_pkg::S_IDLE);
    assign o_res.valid           = r_out_valid;
    assign o_res.cursor_position = r_out_cursor;
    assign o_res.cell_character  = r_out_cell[7:0];
    assign o_res.cell_foreground = r_out_cell[11:8];
    assign o_res.cell_background = r_out_cell[15:12];
    assign o_res.lines_scrolled  = r_out_sc;

endmodule

`default_nettype wire

FILE: hw/rtl/tccs_div.sv
// Restoring divider, one quotient bit per cycle: cell position by column count.
// Depends on tccs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tccs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [tccs_pkg::CELL_AW-1:0]  i_dividend,
    input  wire logic [tccs_pkg::COL_W-1:0]    i_divisor,
    output logic      [tccs_pkg::CELL_AW-1:0]  o_quotient,
    output logic      [tccs_pkg::COL_W-1:0]    o_remainder,
    output tccs_pkg::t_div_status              o_status
);

    logic [tccs_pkg::CELL_AW-1:0]   r_quo;
    logic [tccs_pkg::COL_W-1:0]     r_rem;
    logic [tccs_pkg::COL_W-1:0]     r_dvs;
    logic [tccs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [tccs_pkg::COL_W:0]       trial;
    logic                           fits;
    logic [tccs_pkg::COL_W:0]       trial_sub;

    // trial subtract of the shifted partial remainder
    always_comb begin
        trial     = {r_rem, r_quo[tccs_pkg::CELL_AW-1]};
        fits      = (trial >= {1'b0, r_dvs});
        trial_sub = trial - {1'b0, r_dvs};
    end

    // control: busy while the quotient bits are shifted in, then a one-cycle done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == tccs_pkg::DIV_CNT_W'(tccs_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath: shift dividend into quotient, keep partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tccs_pkg::CELL_AW-2:0], fits};
            r_rem <= fits ? trial_sub[tccs_pkg::COL_W-1:0] : trial[tccs_pkg::COL_W-1:0];
        end
    end

    assign o_quotient    = r_quo;
    assign o_remainder   = r_rem;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule

`default_nettype wire

FILE: hw/rtl/tccs_checker.sv
// Port-level checks for text_console_cursor_scroll, attached with bind.
// Depends on text_console_cursor_scroll and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module tccs_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cmd_valid,
    input wire logic       i_cmd_ready,
    input wire logic       i_res_valid,
    input wire logic       i_res_ready,
    input wire logic [11:0] i_cursor_position,
    input wire logic [7:0] i_cell_character,
    input wire logic [3:0] i_cell_foreground,
    input wire logic [3:0] i_cell_background,
    input wire logic [7:0] i_lines_scrolled
);

    // reset starts the clearing pass, so no request is taken right after it
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> !i_cmd_ready)
        else $error("request ready right after reset");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("request ready in the cycle after an accept");

    // a scrolling request is never a cell read
    a_scroll_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_lines_scrolled != 8'd0) |->
            (i_cell_character == 8'd0) && (i_cell_foreground == 4'd0) &&
            (i_cell_background == 4'd0))
        else $error("cell fields set on a scrolling result");

    // stalled result holds its cursor and scroll count
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_cursor_position) && $stable(i_lines_scrolled))
        else $error("result changed while stalled");

endmodule

bind text_console_cursor_scroll tccs_checker u_tccs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_cursor_position (o_res.cursor_position),
    .i_cell_character  (o_res.cell_character),
    .i_cell_foreground (o_res.cell_foreground),
    .i_cell_background (o_res.cell_background),
    .i_lines_scrolled  (o_res.lines_scrolled)
);

`default_nettype wire

FILE: tb/sv/text_console_cursor_scroll_tb.sv
// Self-checking bench for the text console engine: requests go in over tccs_cmd_if and every
// result is checked against an in-bench screen/cursor predictor, directed cases then random.
// Depends on tccs_pkg, tccs_cmd_if, tccs_res_if and text_console_cursor_scroll.
`timescale 1ns / 1ps

module text_console_cursor_scroll_tb;

    // opcodes the block leaves unused
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RESET_COLUMNS = 80;
    localparam int RESET_ROWS    = 25;
    localparam int HOLD_AT_COUNT = 300;
    localparam int HOLD_CYCLES   = 600;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] character;
        logic [3:0] foreground;
        logic [3:0] background;
        logic [7:0] row;
        logic [7:0] col;
    } t_console_req;

    typedef struct packed {
        logic [11:0] cursor_position;
        logic [7:0]  cell_character;
        logic [3:0]  cell_foreground;
        logic [3:0]  cell_background;
        logic [7:0]  lines_scrolled;
    } t_console_status;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = 1'b0;
    logic [7:0] i_cfg_data = 8'd0;

    tccs_cmd_if cmd_if ();
    tccs_res_if res_if ();

    text_console_cursor_scroll i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd_if),
        .o_res     (res_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor state: screen copy, cursor and geometry registers
    logic [15:0] screen_model [tccs_pkg::CELL_COUNT];
    logic [11:0] cursor_model;
    int unsigned cols_reg;
    int unsigned rows_reg;
    int unsigned step_scrolls;

    t_console_req    cmd_backlog [$];
    t_console_status status_due [$];
    t_console_req    drive_req;
    t_console_status status_head;
    int              error_count = 0;
    int              burst_left = 1;
    int              gap_left = 0;
    int              results_seen = 0;
    int              hold_left = 0;
    int              stall_mode = 0;
    int unsigned     ready_tick = 0;

    function automatic int unsigned eff_columns();
        if (cols_reg == 0) return 1;
        if (cols_reg > tccs_pkg::MAX_COLUMNS) return tccs_pkg::MAX_COLUMNS;
        return cols_reg;
    endfunction

    function automatic int unsigned eff_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > tccs_pkg::MAX_ROWS) return tccs_pkg::MAX_ROWS;
        return rows_reg;
    endfunction

    // shift the visible screen up by k rows and blank what falls in at the bottom
    function automatic void scroll_screen(int unsigned k);
        int unsigned r, c, total, kept, i;
        r = eff_rows();
        c = eff_columns();
        total = r * c;
        kept = (k >= r) ? 0 : (r - k) * c;
        if (k != 0) begin
            for (i = 0; i < kept; i++)
                screen_model[i] = screen_model[i + k * c];
            for (i = kept; i < total; i++)
                screen_model[i] = tccs_pkg::BLANK_CELL;
        end
    endfunction

    // row/column move; a column past the width leaves the cursor alone
    function automatic void move_cursor_model(int unsigned row, int unsigned col);
        int unsigned r, c, n;
        r = eff_rows();
        c = eff_columns();
        if (col < c) begin
            if (row >= r) begin
                n = row - r + 1;
                scroll_screen(n);
                step_scrolls += n;
                row = r - 1;
            end
            cursor_model = 12'((row * c + col) & 32'hFFF);
        end
    endfunction

    // character at the cursor, with pre-scroll for an off-screen cursor
    function automatic void put_char_model(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
        int unsigned r, c, maxp, pos, n;
        r = eff_rows();
        c = eff_columns();
        maxp = r * c;
        pos = cursor_model;
        if (pos >= maxp) begin
            n = (pos - maxp) / c + 1;
            scroll_screen(n);
            step_scrolls += n;
            pos -= n * c;
        end
        if (ch == tccs_pkg::NEWLINE_CODE) begin
            move_cursor_model(pos / c + 1, 0);
        end else begin
            if (pos < tccs_pkg::CELL_COUNT) screen_model[pos] = {bg, fg, ch};
            pos += 1;
            if (pos >= maxp) begin
                scroll_screen(1);
                step_scrolls += 1;
                pos -= c;
            end
            cursor_model = 12'(pos & 32'hFFF);
        end
    endfunction

    // expected status for one accepted request, updating the screen copy
    function automatic t_console_status console_step(t_console_req q);
        t_console_status s;
        logic [15:0]     cell_word;
        int unsigned     i, maxp;
        step_scrolls = 0;
        cell_word = '0;
        case (q.opcode)
            tccs_pkg::OP_PUT: put_char_model(q.character, q.foreground, q.background);
            tccs_pkg::OP_PUT_AT: begin
                move_cursor_model(q.row, q.col);
                put_char_model(q.character, q.foreground, q.background);
            end
            tccs_pkg::OP_MOVE: move_cursor_model(q.row, q.col);
            tccs_pkg::OP_CLEAR: begin
                maxp = eff_rows() * eff_columns();
                for (i = 0; i < maxp; i++)
                    screen_model[i] = tccs_pkg::BLANK_CELL;
                cursor_model = '0;
            end
            tccs_pkg::OP_READ: begin
                if (q.row < eff_rows() && q.col < eff_columns())
                    cell_word = screen_model[q.row * eff_columns() + q.col];
            end
            default: ;
        endcase
        s.cursor_position = cursor_model;
        s.cell_character  = cell_word[7:0];
        s.cell_foreground = cell_word[11:8];
        s.cell_background = cell_word[15:12];
        s.lines_scrolled  = (step_scrolls > 255) ? 8'd255 : 8'(step_scrolls);
        return s;
    endfunction

    function automatic t_console_req make_req(logic [2:0] op, logic [7:0] ch, logic [3:0] fg,
                                              logic [3:0] bg, logic [7:0] row, logic [7:0] col);
        t_console_req q;
        q.opcode = op;
        q.character = ch;
        q.foreground = fg;
        q.background = bg;
        q.row = row;
        q.col = col;
        return q;
    endfunction

    // random request, mostly on screen, some past the edges
    function automatic t_console_req random_req();
        t_console_req q;
        int unsigned  pick, r, c;
        r = eff_rows();
        c = eff_columns();
        q.character  = 8'($urandom_range(0, 255));
        q.foreground = 4'($urandom_range(0, 15));
        q.background = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 40) q.opcode = tccs_pkg::OP_PUT;
        else if (pick < 55) q.opcode = tccs_pkg::OP_PUT_AT;
        else if (pick < 70) q.opcode = tccs_pkg::OP_MOVE;
        else if (pick < 92) q.opcode = tccs_pkg::OP_READ;
        else if (pick < 95) q.opcode = tccs_pkg::OP_CLEAR;
        else if (pick < 97) q.opcode = OP_SPARE_5;
        else if (pick < 98) q.opcode = OP_SPARE_6;
        else q.opcode = OP_SPARE_7;
        if (q.opcode == tccs_pkg::OP_PUT && $urandom_range(0, 7) == 0)
            q.character = tccs_pkg::NEWLINE_CODE;
        pick = $urandom_range(0, 9);
        if (pick < 7) q.row = 8'($urandom_range(0, r - 1));
        else if (pick < 9) q.row = 8'($urandom_range(r, r + 2));
        else q.row = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8) q.col = 8'($urandom_range(0, c - 1));
        else q.col = 8'($urandom_range(0, 255));
        return q;
    endfunction

    task automatic check_field(string field, logic [11:0] want, logic [11:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // geometry write; the predictor follows at the same edge
    task automatic write_register(logic idx, logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tccs_pkg::REG_COLUMNS) cols_reg = data;
        else rows_reg = data & 8'h3F;
    endtask

    // settled values are read away from the active edge
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || cmd_if.valid || status_due.size() != 0);
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) status_due.push_back(console_step(drive_req));
            if (!cmd_if.valid || cmd_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_if.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    drive_req = cmd_backlog.pop_front();
                    cmd_if.valid      <= 1'b1;
                    cmd_if.opcode     <= drive_req.opcode;
                    cmd_if.character  <= drive_req.character;
                    cmd_if.foreground <= drive_req.foreground;
                    cmd_if.background <= drive_req.background;
                    cmd_if.row        <= drive_req.row;
                    cmd_if.col        <= drive_req.col;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            ready_tick++;
            if (res_if.valid && res_if.ready) begin
                if (status_due.size() == 0) begin
                    error_count++;
                    $display("%0t: result with no request outstanding, expected none, actual %0h",
                             $time, res_if.cursor_position);
                end else begin
                    status_head = status_due.pop_front();
                    check_field("cursor_position", status_head.cursor_position,
                                res_if.cursor_position);
                    check_field("cell_character", status_head.cell_character,
                                res_if.cell_character);
                    check_field("cell_foreground", status_head.cell_foreground,
                                res_if.cell_foreground);
                    check_field("cell_background", status_head.cell_background,
                                res_if.cell_background);
                    check_field("lines_scrolled", status_head.lines_scrolled,
                                res_if.lines_scrolled);
                end
                results_seen++;
                if (results_seen == HOLD_AT_COUNT) hold_left = HOLD_CYCLES;
                if (results_seen % 50 == 0) stall_mode = $urandom_range(0, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 3) != 0);
                    2: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default: res_if.ready <= (ready_tick % 16 < 10);
                endcase
            end
        end
    end

    // stimulus: directed cases, then random phases over many geometries
    initial begin
        int          phase_idx;
        int unsigned n_items;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = tccs_pkg::OP_PUT;
        cmd_if.character = 8'd0;
        cmd_if.foreground = 4'd0;
        cmd_if.background = 4'd0;
        cmd_if.row = 8'd0;
        cmd_if.col = 8'd0;
        res_if.ready = 1'b0;
        for (int i = 0; i < tccs_pkg::CELL_COUNT; i++) screen_model[i] = tccs_pkg::BLANK_CELL;
        cursor_model = '0;
        cols_reg = RESET_COLUMNS;
        rows_reg = RESET_ROWS;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: write, read back, newline, edges, ignored moves, unused opcodes, clear
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, 8'h48, 4'd7, 4'd1, 8'd0, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE,
                                       4'd3, 4'd3, 8'd0, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT_AT, 8'hFF, 4'd15, 4'd15, 8'd24, 8'd79));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 8'd23, 8'd79));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_MOVE, 8'd0, 4'd0, 4'd0, 8'd0, 8'd80));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT_AT, 8'h00, 4'd0, 4'd0, 8'd3, 8'd200));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_MOVE, 8'd0, 4'd0, 4'd0, 8'd255, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 8'd25, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 8'd0, 8'd255));
        cmd_backlog.push_back(make_req(OP_SPARE_5, 8'hAA, 4'd5, 4'd10, 8'd1, 8'd1));
        cmd_backlog.push_back(make_req(OP_SPARE_6, 8'h55, 4'd10, 4'd5, 8'd2, 8'd2));
        cmd_backlog.push_back(make_req(OP_SPARE_7, 8'hFF, 4'd15, 4'd15, 8'd255, 8'd255));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_CLEAR, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_READ, 8'd0, 4'd0, 4'd0, 8'd0, 8'd0));
        wait_idle();

        // zero geometry acts as a single cell; scroll count saturates
        write_register(tccs_pkg::REG_COLUMNS, 8'd0);
        write_register(tccs_pkg::REG_ROWS, 8'd0);
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, 8'h78, 4'd2, 4'd4, 8'd0, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT_AT, 8'h79, 4'd6, 4'd8, 8'd255, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE,
                                       4'd0, 4'd0, 8'd0, 8'd0));
        wait_idle();

        // oversized values clamp to the full store; last cell and bottom newline
        write_register(tccs_pkg::REG_COLUMNS, 8'd255);
        write_register(tccs_pkg::REG_ROWS, 8'd63);
        cmd_backlog.push_back(make_req(tccs_pkg::OP_MOVE, 8'd0, 4'd0, 4'd0, 8'd31, 8'd127));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, 8'h7A, 4'd9, 4'd12, 8'd0, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE,
                                       4'd0, 4'd0, 8'd0, 8'd0));
        wait_idle();

        // shrink without clearing: cursor left off screen, rows upper bits ignored
        write_register(tccs_pkg::REG_COLUMNS, 8'd3);
        write_register(tccs_pkg::REG_ROWS, 8'h42);
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, 8'h71, 4'd1, 4'd14, 8'd0, 8'd0));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_MOVE, 8'd0, 4'd0, 4'd0, 8'd1, 8'd2));
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE,
                                       4'd0, 4'd0, 8'd0, 8'd0));
        wait_idle();
        write_register(tccs_pkg::REG_COLUMNS, 8'd2);
        write_register(tccs_pkg::REG_ROWS, 8'd1);
        cmd_backlog.push_back(make_req(tccs_pkg::OP_PUT, tccs_pkg::NEWLINE_CODE,
                                       4'd0, 4'd0, 8'd0, 8'd0));
        wait_idle();
        write_register(tccs_pkg::REG_COLUMNS, 8'd128);
        write_register(tccs_pkg::REG_ROWS, 8'd32);

        // random phases, mostly small screens, two with large screens
        for (phase_idx = 0; phase_idx < 26; phase_idx++) begin
            wait_idle();
            if (phase_idx % 12 == 5) begin
                write_register(tccs_pkg::REG_COLUMNS, 8'($urandom_range(100, 255)));
                write_register(tccs_pkg::REG_ROWS, 8'($urandom_range(24, 63)));
                n_items = 12;
            end else begin
                if (phase_idx < 2 || $urandom_range(0, 3) != 0)
                    write_register(tccs_pkg::REG_COLUMNS, 8'($urandom_range(0, 24)));
                if (phase_idx < 2 || $urandom_range(0, 3) != 0)
                    write_register(tccs_pkg::REG_ROWS,
                                   8'(($urandom_range(0, 3) << 6) | $urandom_range(0, 10)));
                n_items = 80;
            end
            repeat (n_items) cmd_backlog.push_back(random_req());
        end

        wait_idle();
        repeat (64) @(posedge i_clk);
        if (status_due.size() != 0) begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, status_due.size());
        end
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
